[rtl/cse_pkg.sv]
// cycle sort engine: shared field widths
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package cse_pkg;

	localparam int VALUE_BITS = 31;

endpackage

`default_nettype wire

[rtl/cse_ifs.sv]
// cycle sort engine: input and result channel interfaces (valid/ready)
// depends on cse_pkg for field widths
`default_nettype none

interface cse_in_if import cse_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic                  last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface cse_out_if import cse_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] sorted_value;
	logic                  last_res;
	logic                  overflow;

	modport source (output valid, output sorted_value, output last_res, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input last_res, input overflow,
		output ready);
endinterface

`default_nettype wire

[rtl/cycle_sort_engine.sv]
// cycle sort engine top level: load, in-place cycle sort over one memory, emission
// depends on cse_pkg and the channel interfaces in cse_ifs.sv
`default_nettype none

// Collects up to DEPTH values, one per input transaction, and the transaction marked last
// closes the set; further values are dropped and flagged as overflow on every result.
// The set is sorted in place in a single memory (one write and one registered read per
// cycle) and then streamed out in ascending order, the final result marked. Loading keeps
// the input ready, so transactions can follow back to back. For a set of n values, each
// visit of a position runs the fetch, the value latch, a counting scan through the memory
// read port and the target check, with a step-back check per equal entry stepped over and
// a write-back for a swap. Every swap puts one value in its final place, so with s swaps
// (s below n) there are n + s visits. Emission then gives one result per cycle while the
// receiver is ready. Input is taken only while loading; the last result may still be
// waiting while the next set loads.
module cycle_sort_engine import cse_pkg::*; #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 31
) (
	input  wire         clk,
	input  wire         arst_n,
	cse_in_if.sink      din,
	cse_out_if.source   dout
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (VALUE_WIDTH > VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;

	typedef enum logic [2:0] {
		S_LOAD,
		S_FETCH,
		S_VAL,
		S_SCAN,
		S_BACK,
		S_BCHK,
		S_SWAP,
		S_EMIT
	} state_t;

	logic [VALUE_WIDTH-1:0] mem [DEPTH];

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          i_q;
	logic [CW-1:0]          j_q;
	logic [CW-1:0]          cnt_q;
	logic [AW-1:0]          t_q;
	logic [AW-1:0]          k_q;
	logic [VALUE_WIDTH-1:0] v_q;
	logic [VALUE_WIDTH-1:0] tmp_q;
	logic [VALUE_WIDTH-1:0] rdata_q;
	logic                   dropped_q;
	logic                   out_valid_q;
	logic [VALUE_BITS-1:0]  out_value_q;
	logic                   out_last_q;
	logic                   out_ovf_q;

	logic                   acc;
	logic                   room;
	logic                   out_free;
	logic                   emit_now;
	logic                   final_k;
	logic                   step_back;
	logic [CW-1:0]          cnt_inc;
	logic [XW-1:0]          in_ext;
	logic [XW-1:0]          out_ext;
	logic                   rd_en;
	logic [AW-1:0]          raddr;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [VALUE_WIDTH-1:0] wdata;

	assign din.ready = (state_q == S_LOAD);
	assign acc       = din.valid && din.ready;
	assign room      = (count_q < CW'(DEPTH));
	assign out_free  = !out_valid_q || dout.ready;
	assign emit_now  = (state_q == S_EMIT) && out_free;
	assign final_k   = ((CW'(k_q) + CW'(1)) == count_q);
	assign step_back = (t_q != '0) && (rdata_q == v_q);
	assign cnt_inc   = cnt_q + CW'(rdata_q <= v_q);
	assign in_ext    = XW'(din.value);
	assign out_ext   = XW'(rdata_q);

	assign dout.valid        = out_valid_q;
	assign dout.sorted_value = out_value_q;
	assign dout.last_res     = out_last_q;
	assign dout.overflow     = out_ovf_q;

	// memory port control
	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = in_ext[VALUE_WIDTH-1:0];
		case (state_q)
			S_LOAD: begin
				we    = acc && room;
				waddr = count_q[AW-1:0];
			end
			S_FETCH: begin
				// once every position is done, fetch the first value for emission
				rd_en = 1'b1;
				raddr = (i_q == count_q) ? '0 : i_q[AW-1:0];
			end
			S_VAL: begin
				rd_en = 1'b1;
				raddr = '0;
			end
			S_SCAN: begin
				rd_en = (j_q != count_q);
				raddr = j_q[AW-1:0];
			end
			S_BACK: begin
				rd_en = (CW'(t_q) != i_q);
				raddr = t_q;
			end
			S_BCHK: begin
				we    = !step_back;
				waddr = t_q;
				wdata = v_q;
			end
			S_SWAP: begin
				we    = 1'b1;
				waddr = i_q[AW-1:0];
				wdata = tmp_q;
			end
			S_EMIT: begin
				rd_en = out_free && !final_k;
				raddr = k_q + AW'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			t_q         <= '0;
			k_q         <= '0;
			v_q         <= '0;
			tmp_q       <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (acc) begin
						if (room) begin
							count_q <= count_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (din.last) begin
							i_q     <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					if (i_q == count_q) begin
						k_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_VAL;
					end
				end
				S_VAL: begin
					v_q     <= rdata_q;
					j_q     <= CW'(1);
					cnt_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					cnt_q <= cnt_inc;
					if (j_q == count_q) begin
						t_q     <= AW'(cnt_inc - CW'(1));
						state_q <= S_BACK;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_BACK: begin
					if (CW'(t_q) == i_q) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_FETCH;
					end else begin
						state_q <= S_BCHK;
					end
				end
				S_BCHK: begin
					if (step_back) begin
						t_q     <= t_q - AW'(1);
						state_q <= S_BACK;
					end else begin
						tmp_q   <= rdata_q;
						state_q <= S_SWAP;
					end
				end
				S_SWAP: begin
					state_q <= S_FETCH;
				end
				S_EMIT: begin
					// first read of the run was issued in the fetch state
					if (out_free) begin
						out_value_q <= out_ext[VALUE_BITS-1:0];
						out_last_q  <= final_k;
						out_ovf_q   <= dropped_q;
						if (final_k) begin
							count_q   <= '0;
							i_q       <= '0;
							t_q       <= '0;
							dropped_q <= 1'b0;
							state_q   <= S_LOAD;
						end else begin
							k_q <= k_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
